[sv/sgdlpu_pkg.sv]
// Shared types, codes and helpers for the 1D SGD layout position update block.
// No dependencies.
`default_nettype none

package sgdlpu_pkg;

    // Item modes carried by a transaction.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TERM  = 2'd2;
    localparam logic [1:0] MODE_START = 2'd3;

    // Configuration register byte addresses.
    localparam logic [2:0] ADDR_LEARNING_RATE  = 3'd0;
    localparam logic [2:0] ADDR_STOP_THRESHOLD = 3'd4;

    typedef logic [63:0] t_pos;
    typedef logic [62:0] t_step;

    // Move a signed position by a magnitude up or down, saturating to 64 bits.
    function automatic t_pos sat_move(input t_pos x, input logic down, input t_step mag);
        logic [64:0] r;
        t_pos res;
        if (down) begin
            r = {x[63], x} - {2'b00, mag};
        end else begin
            r = {x[63], x} + {2'b00, mag};
        end
        if (r[64:63] == 2'b01) begin
            res = {1'b0, {63{1'b1}}};
        end else if (r[64:63] == 2'b10) begin
            res = {1'b1, {63{1'b0}}};
        end else begin
            res = r[63:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/sgd_layout_position_update_top.sv]
// Top level of the 1D SGD layout position update block.
// Depends on sgdlpu_pkg and sgdlpu_ram.
`default_nettype none

// One transaction is handled at a time. An update term runs a radix-2
// restoring divider that computes eta/d one quotient bit per cycle, followed
// by position reads, two partial-product multiplies and two position
// write-backs through the single write port of the position memory. When
// NODES is below 65536, each item first reduces the node indexes modulo
// NODES. A finished result waits in the output register while the next
// transaction is accepted.
module sgd_layout_position_update_top #(
    parameter int NODES     = 65536,
    parameter int FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_mode,
    input  wire  [15:0] i_node_a,
    input  wire  [15:0] i_node_b,
    input  wire  [39:0] i_step_pos_a,
    input  wire  [39:0] i_step_pos_b,
    input  wire         i_move_a,
    input  wire         i_move_b,
    input  wire  [63:0] i_load_value,
    // Output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [63:0] o_read_value,
    output logic [62:0] o_step_abs,
    output logic [62:0] o_max_step,
    output logic [31:0] o_term_count,
    output logic        o_skipped,
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import sgdlpu_pkg::*;

    localparam int AW       = $clog2(NODES);
    localparam bit NEED_WRAP = (NODES < 65536);
    localparam int SH_L     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_R     = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WRAP = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_RDW  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_RDA  = 4'd5;
    localparam logic [3:0] S_RDB  = 4'd6;
    localparam logic [3:0] S_DX   = 4'd7;
    localparam logic [3:0] S_PREP = 4'd8;
    localparam logic [3:0] S_MUL1 = 4'd9;
    localparam logic [3:0] S_MUL2 = 4'd10;
    localparam logic [3:0] S_SUM  = 4'd11;
    localparam logic [3:0] S_WA   = 4'd12;
    localparam logic [3:0] S_WB   = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0]  r_state;
    logic [31:0] r_lr, r_thr;
    logic [62:0] r_largest;
    logic [31:0] r_count;

    // Latched transaction fields.
    logic [1:0]  r_mode;
    logic [15:0] r_na, r_nb;
    logic        r_mva, r_mvb;
    logic [63:0] r_load;
    logic [39:0] r_d;
    logic [3:0]  r_wcnt;

    // Datapath registers.
    logic [39:0] r_rem;
    logic [47:0] r_quo;
    logic [5:0]  r_dcnt;
    logic [32:0] r_mu;
    logic [63:0] r_xa, r_xb, r_adx, r_m, r_newa;
    logic        r_dxneg, r_rxneg;
    logic [64:0] r_plo, r_phi;
    logic [62:0] r_step;

    // Result staging.
    logic [63:0] r_rv;
    logic        r_skip;
    logic [62:0] r_rep_max;
    logic [31:0] r_rep_cnt;
    logic        r_use_rep;

    // Memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr, addr_a, addr_b;
    logic [63:0]   ram_wdata, ram_rdata;

    logic [AW+15:0] ext_a, ext_b;
    assign ext_a  = {{AW{1'b0}}, r_na};
    assign ext_b  = {{AW{1'b0}}, r_nb};
    assign addr_a = ext_a[AW-1:0];
    assign addr_b = ext_b[AW-1:0];

    // Combinational helpers.
    logic        in_acc, out_free, cfg_wr;
    logic [31:0] wrap_ref;
    logic [40:0] rem_sh;
    logic        div_ge;
    logic [63:0] thr_fixed, adx1, dq, sat_a, base_b, sat_b;
    logic        dxneg1, delta_neg;
    logic [64:0] psum;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_in_stall = (r_state != S_IDLE);
    assign pready   = 1'b1;

    assign wrap_ref  = 32'(NODES) << r_wcnt;
    assign rem_sh    = {r_rem, r_quo[47]};
    assign div_ge    = (rem_sh >= {1'b0, r_d});
    assign thr_fixed = ({32'd0, r_thr} << SH_L) >> SH_R;
    assign adx1      = (r_adx == 64'd0) ? 64'd1 : r_adx;
    assign dxneg1    = (r_adx == 64'd0) ? 1'b0 : r_dxneg;
    assign dq        = {24'd0, r_d} << FRAC_BITS;
    assign delta_neg = (adx1 < dq);
    assign psum      = r_phi + {32'd0, r_plo[64:32]};
    assign sat_a     = sat_move(r_xa, !r_rxneg, r_step);
    assign base_b    = (r_na == r_nb && r_mva) ? r_newa : r_xb;
    assign sat_b     = sat_move(base_b, r_rxneg, r_step);

    // Memory write and read port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_a;
        ram_wdata = r_load;
        ram_raddr = (r_state == S_RDB) ? addr_b : addr_a;
        if (r_state == S_DISP && r_mode == MODE_LOAD) begin
            ram_we = 1'b1;
        end else if (r_state == S_WA && r_mva) begin
            ram_we    = 1'b1;
            ram_wdata = sat_a;
        end else if (r_state == S_WB && r_mvb) begin
            ram_we    = 1'b1;
            ram_waddr = addr_b;
            ram_wdata = sat_b;
        end
    end

    sgdlpu_ram #(
        .WIDTH (64),
        .DEPTH (NODES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration register reads.
    always_comb begin
        if (paddr == ADDR_LEARNING_RATE) begin
            prdata = r_lr;
        end else if (paddr == ADDR_STOP_THRESHOLD) begin
            prdata = r_thr;
        end else begin
            prdata = 32'd0;
        end
    end

    // Control state: sequencer, configuration, iteration counters, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lr        <= 32'd65536;
            r_thr       <= 32'd0;
            r_largest   <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && paddr == ADDR_LEARNING_RATE) begin
                r_lr <= pwdata;
            end
            if (cfg_wr && paddr == ADDR_STOP_THRESHOLD) begin
                r_thr <= pwdata;
            end
            // A result taken while a new one is loaded keeps valid high below.
            if (o_out_valid && !i_out_stall && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= NEED_WRAP ? S_WRAP : S_DISP;
                    end
                end
                S_WRAP: begin
                    if (r_wcnt == 4'd0) begin
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    unique case (r_mode)
                        MODE_LOAD:  r_state <= S_OUT;
                        MODE_READ:  r_state <= S_RDW;
                        MODE_START: begin
                            r_largest <= thr_fixed[62:0];
                            r_count   <= '0;
                            r_state   <= S_OUT;
                        end
                        MODE_TERM: begin
                            if (!r_mva && !r_mvb) begin
                                if (r_count != '1) begin
                                    r_count <= r_count + 32'd1;
                                end
                                r_state <= S_OUT;
                            end else if (r_d == 40'd0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    endcase
                end
                S_RDW:  r_state <= S_OUT;
                S_DIV: begin
                    if (r_dcnt == 6'd47) begin
                        r_state <= S_RDA;
                    end
                end
                S_RDA:  r_state <= S_RDB;
                S_RDB:  r_state <= S_DX;
                S_DX:   r_state <= S_PREP;
                S_PREP: r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_SUM;
                S_SUM:  r_state <= S_WA;
                S_WA: begin
                    if (r_step > r_largest) begin
                        r_largest <= r_step;
                    end
                    if (r_count != '1) begin
                        r_count <= r_count + 32'd1;
                    end
                    r_state <= S_WB;
                end
                S_WB:   r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath and payload registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_mode    <= i_mode;
                    r_na      <= i_node_a;
                    r_nb      <= i_node_b;
                    r_mva     <= i_move_a;
                    r_mvb     <= i_move_b;
                    r_load    <= i_load_value;
                    r_d       <= (i_step_pos_a > i_step_pos_b) ? i_step_pos_a - i_step_pos_b
                                                               : i_step_pos_b - i_step_pos_a;
                    r_wcnt    <= 4'd15;
                    r_rv      <= '0;
                    r_step    <= '0;
                    r_skip    <= 1'b0;
                    r_use_rep <= 1'b0;
                end
            end
            S_WRAP: begin
                // One restoring step of the index reduction for both nodes.
                if ({16'd0, r_na} >= wrap_ref) begin
                    r_na <= r_na - wrap_ref[15:0];
                end
                if ({16'd0, r_nb} >= wrap_ref) begin
                    r_nb <= r_nb - wrap_ref[15:0];
                end
                r_wcnt <= r_wcnt - 4'd1;
            end
            S_DISP: begin
                r_rem  <= '0;
                r_quo  <= {r_lr, 16'd0};
                r_dcnt <= '0;
                if (r_mode == MODE_START) begin
                    r_rep_max <= r_largest;
                    r_rep_cnt <= r_count;
                    r_use_rep <= 1'b1;
                end
                if (r_mode == MODE_TERM && (!r_mva && !r_mvb || r_d == 40'd0)) begin
                    r_skip <= 1'b1;
                end
            end
            S_RDW: r_rv <= ram_rdata;
            S_DIV: begin
                // One quotient bit of eta * 2^16 / d per cycle.
                r_rem  <= div_ge ? 40'(rem_sh - {1'b0, r_d}) : rem_sh[39:0];
                r_quo  <= {r_quo[46:0], div_ge};
                r_dcnt <= r_dcnt + 6'd1;
            end
            S_RDB: r_xa <= ram_rdata;
            S_DX: begin
                r_xb    <= ram_rdata;
                r_dxneg <= ($signed(r_xa) < $signed(ram_rdata));
                r_adx   <= ($signed(r_xa) < $signed(ram_rdata)) ? ram_rdata - r_xa
                                                                : r_xa - ram_rdata;
                // Clamp mu to one.
                if (r_quo[47:33] != '0 || (r_quo[32] && r_quo[31:0] != '0)) begin
                    r_mu <= {1'b1, 32'd0};
                end else begin
                    r_mu <= r_quo[32:0];
                end
            end
            S_PREP: begin
                r_m     <= delta_neg ? dq - adx1 : adx1 - dq;
                r_rxneg <= delta_neg ^ dxneg1;
            end
            S_MUL1: r_plo  <= r_mu * r_m[31:0];
            S_MUL2: r_phi  <= r_mu * r_m[63:32];
            S_SUM:  r_step <= psum[63:1];
            S_WA:   r_newa <= sat_a;
            S_OUT: begin
                if (out_free) begin
                    o_read_value <= r_rv;
                    o_step_abs   <= r_step;
                    o_max_step   <= r_use_rep ? r_rep_max : r_largest;
                    o_term_count <= r_use_rep ? r_rep_cnt : r_count;
                    o_skipped    <= r_skip;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/sgdlpu_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sgdlpu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the 1D SGD layout position update block.
// Drives update, load, read and start transactions, predicts each result and
// checks it. Depends on sgdlpu_pkg and sgd_layout_position_update_top.
`timescale 1ns / 100ps

module tb_top;
    import sgdlpu_pkg::*;

    localparam int MAX_SHOWN = 10;
    localparam int IDLE_LIMIT = 4000;
    localparam logic signed [64:0] POS_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] POS_LO = -POS_HI - 65'sd1;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] node_a;
        logic [15:0] node_b;
        logic [39:0] step_pos_a;
        logic [39:0] step_pos_b;
        logic        move_a;
        logic        move_b;
        logic [63:0] load_value;
    } layout_item_t;

    typedef struct {
        logic [63:0] read_value;
        logic [62:0] step_abs;
        logic [62:0] max_step;
        logic [31:0] term_count;
        logic        skipped;
    } layout_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_mode = '0;
    logic [15:0] i_node_a = '0;
    logic [15:0] i_node_b = '0;
    logic [39:0] i_step_pos_a = '0;
    logic [39:0] i_step_pos_b = '0;
    logic        i_move_a = 1'b0;
    logic        i_move_b = 1'b0;
    logic [63:0] i_load_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_read_value;
    logic [62:0] o_step_abs;
    logic [62:0] o_max_step;
    logic [31:0] o_term_count;
    logic        o_skipped;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted block state.
    logic [63:0] node_pos [65536];
    logic [62:0] peak_step;
    logic [31:0] term_total;
    logic [31:0] eta_reg;
    logic [31:0] threshold_reg;
    logic [15:0] loaded_nodes [$];
    bit          is_loaded [65536];

    layout_result_t pending_results [$];
    layout_result_t head_result;
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    int  stall_burst = 0;

    sgd_layout_position_update_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(i_mode), .i_node_a(i_node_a), .i_node_b(i_node_b),
        .i_step_pos_a(i_step_pos_a), .i_step_pos_b(i_step_pos_b),
        .i_move_a(i_move_a), .i_move_b(i_move_b), .i_load_value(i_load_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_read_value(o_read_value), .o_step_abs(o_step_abs),
        .o_max_step(o_max_step), .o_term_count(o_term_count), .o_skipped(o_skipped),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Moves a position up or down by a magnitude, clamped to the signed range.
    function automatic logic [63:0] nudge_pos(logic [63:0] x, logic down, logic [62:0] mag);
        logic signed [64:0] s;
        if (down) begin
            s = $signed({x[63], x}) - $signed({2'b00, mag});
        end else begin
            s = $signed({x[63], x}) + $signed({2'b00, mag});
        end
        if (s > POS_HI) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (s < POS_LO) return 64'h8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // Applies one transaction to the predicted state and returns its result.
    function automatic layout_result_t apply_layout_item(layout_item_t it);
        layout_result_t r;
        logic [39:0] span_len;
        logic signed [63:0] xa, xb;
        logic dx_neg, delta_neg, move_neg;
        logic [63:0] adx, dq, m;
        logic [47:0] mu_full;
        logic [32:0] mu;
        logic [127:0] prod;
        logic [62:0] st;
        r = '{default: '0};
        r.max_step = peak_step;
        r.term_count = term_total;
        case (it.mode)
            MODE_LOAD: begin
                node_pos[it.node_a] = it.load_value;
            end
            MODE_READ: begin
                r.read_value = node_pos[it.node_a];
            end
            MODE_START: begin
                peak_step = {31'd0, threshold_reg};
                term_total = '0;
            end
            default: begin
                span_len = (it.step_pos_a > it.step_pos_b) ? it.step_pos_a - it.step_pos_b
                                                           : it.step_pos_b - it.step_pos_a;
                if (!it.move_a && !it.move_b) begin
                    // Both frozen: counted, nothing moves.
                    r.skipped = 1'b1;
                    if (term_total != 32'hFFFF_FFFF) term_total++;
                end else if (span_len == 0) begin
                    r.skipped = 1'b1;
                end else begin
                    xa = node_pos[it.node_a];
                    xb = node_pos[it.node_b];
                    dx_neg = xa < xb;
                    adx = dx_neg ? xb - xa : xa - xb;
                    if (adx == 0) begin
                        adx = 64'd1;
                        dx_neg = 1'b0;
                    end
                    mu_full = {eta_reg, 16'h0000} / {8'd0, span_len};
                    mu = (mu_full > 48'h1_0000_0000) ? 33'h1_0000_0000 : mu_full[32:0];
                    dq = {8'd0, span_len, 16'h0000};
                    delta_neg = adx < dq;
                    m = delta_neg ? dq - adx : adx - dq;
                    prod = {95'd0, mu} * {64'd0, m};
                    st = prod[95:33];
                    r.step_abs = st;
                    if (st > peak_step) peak_step = st;
                    move_neg = delta_neg != dx_neg;
                    if (it.move_a) node_pos[it.node_a] = nudge_pos(node_pos[it.node_a], !move_neg, st);
                    if (it.move_b) node_pos[it.node_b] = nudge_pos(node_pos[it.node_b], move_neg, st);
                    if (term_total != 32'hFFFF_FFFF) term_total++;
                end
                r.max_step = peak_step;
                r.term_count = term_total;
            end
        endcase
        if (it.mode == MODE_LOAD || it.mode == MODE_READ) begin
            r.max_step = peak_step;
            r.term_count = term_total;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] %s: expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    // Sends one transaction, with an optional random gap first.
    task automatic send_item(input layout_item_t it);
        if (!no_gaps && $urandom_range(0, 9) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_mode = it.mode;
        i_node_a = it.node_a;
        i_node_b = it.node_b;
        i_step_pos_a = it.step_pos_a;
        i_step_pos_b = it.step_pos_b;
        i_move_a = it.move_a;
        i_move_b = it.move_b;
        i_load_value = it.load_value;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.mode == MODE_LOAD && !is_loaded[it.node_a]) begin
            is_loaded[it.node_a] = 1'b1;
            loaded_nodes.insert(loaded_nodes.size(), it.node_a);
        end
        pending_results.insert(pending_results.size(), apply_layout_item(it));
        @(negedge i_clk);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_results_drained();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes a register, then reads it back.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_LEARNING_RATE) eta_reg = value;
        else threshold_reg = value;
        @(negedge i_clk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value) note_mismatch("register readback", {32'd0, value}, {32'd0, prdata});
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    function automatic layout_item_t make_item(logic [1:0] mode, logic [15:0] a, logic [15:0] b,
                                               logic [39:0] pa, logic [39:0] pb,
                                               logic ma, logic mb, logic [63:0] lv);
        layout_item_t it;
        it.mode = mode; it.node_a = a; it.node_b = b;
        it.step_pos_a = pa; it.step_pos_b = pb;
        it.move_a = ma; it.move_b = mb; it.load_value = lv;
        return it;
    endfunction

    function automatic logic [15:0] pick_loaded();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    // Random transaction; updates and reads only touch loaded nodes.
    function automatic layout_item_t random_item();
        layout_item_t it;
        int sel;
        logic [39:0] base;
        sel = $urandom_range(0, 99);
        base = 40'({$urandom(), $urandom()});
        it.node_a = pick_loaded();
        it.node_b = pick_loaded();
        it.step_pos_a = base;
        it.step_pos_b = ($urandom_range(0, 7) == 0) ? 40'({$urandom(), $urandom()})
                                                    : base + 40'($urandom_range(0, 2000));
        it.move_a = $urandom_range(0, 3) != 0;
        it.move_b = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 3) == 0)
            it.load_value = {$urandom(), $urandom()};
        else
            it.load_value = ((64'($urandom_range(0, 4000)) - 64'd2000) << 16)
                            | 64'($urandom_range(0, 65535));
        if (sel < 15) begin
            it.mode = MODE_LOAD;
            if ($urandom_range(0, 1) == 0) it.node_a = 16'($urandom());
            it.node_b = 16'($urandom());
        end else if (sel < 30) begin
            it.mode = MODE_READ;
        end else if (sel < 92) begin
            it.mode = MODE_TERM;
        end else begin
            it.mode = MODE_START;
            it.node_a = 16'($urandom());
            it.node_b = 16'($urandom());
        end
        return it;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing expected", 64'd0, o_read_value);
            end else begin
                head_result = pending_results.pop_front();
                if (o_read_value !== head_result.read_value)
                    note_mismatch("read_value", head_result.read_value, o_read_value);
                if (o_step_abs !== head_result.step_abs)
                    note_mismatch("step_abs", {1'b0, head_result.step_abs}, {1'b0, o_step_abs});
                if (o_max_step !== head_result.max_step)
                    note_mismatch("max_step", {1'b0, head_result.max_step}, {1'b0, o_max_step});
                if (o_term_count !== head_result.term_count)
                    note_mismatch("term_count", {32'd0, head_result.term_count},
                                  {32'd0, o_term_count});
                if (o_skipped !== head_result.skipped)
                    note_mismatch("skipped", {63'd0, head_result.skipped}, {63'd0, o_skipped});
            end
        end
    end

    // Receiver stalls in random bursts.
    always @(negedge i_clk) begin
        if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            i_out_stall <= 1'b1;
        end else if (!no_gaps && $urandom_range(0, 11) == 0) begin
            stall_burst <= $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transaction while something is waiting.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (pending_results.size() == 0 && !i_in_valid)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_registers();
        write_register(ADDR_LEARNING_RATE, 32'h0001_0000);
        write_register(ADDR_STOP_THRESHOLD, 32'h0000_0000);
    endtask

    // Extremes and each special case of the update.
    task automatic test_directed();
        send_item(make_item(MODE_LOAD, 16'd0, 16'hFFFF, '0, '0, 0, 0, 64'd0));
        send_item(make_item(MODE_LOAD, 16'hFFFF, 16'd0, '0, '0, 1, 1, 64'd100 << 16));
        send_item(make_item(MODE_LOAD, 16'd1, 16'd0, '0, '0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
        send_item(make_item(MODE_LOAD, 16'd2, 16'd0, '0, '0, 0, 0, 64'h8000_0000_0000_0000));
        send_item(make_item(MODE_LOAD, 16'd3, 16'd0, '0, '0, 0, 0, 64'd5 << 16));
        send_item(make_item(MODE_LOAD, 16'd4, 16'd0, '0, '0, 0, 0, 64'd5 << 16));
        send_item(make_item(MODE_READ, 16'd1, 16'd0, '0, '0, 0, 0, '0));
        send_item(make_item(MODE_READ, 16'd2, 16'd0, '0, '0, 0, 0, '0));
        send_item(make_item(MODE_TERM, 16'd0, 16'hFFFF, '0, 40'hFF_FFFF_FFFF, 1, 1, '0));
        send_item(make_item(MODE_TERM, 16'd0, 16'd3, 40'd10, 40'd3, 1, 1, '0));
        send_item(make_item(MODE_TERM, 16'd1, 16'd2, 40'd0, 40'd9, 0, 0, '0));
        send_item(make_item(MODE_TERM, 16'd0, 16'd3, 40'd7, 40'd7, 1, 1, '0));
        send_item(make_item(MODE_TERM, 16'd3, 16'd3, 40'd0, 40'd2, 1, 1, '0));
        send_item(make_item(MODE_TERM, 16'd3, 16'd4, 40'd0, 40'd3, 1, 1, '0));
        send_item(make_item(MODE_TERM, 16'd1, 16'd2, 40'd0, 40'd1, 1, 1, '0));
        send_item(make_item(MODE_TERM, 16'd2, 16'd1, 40'd1, 40'd0, 1, 0, '0));
        send_item(make_item(MODE_READ, 16'd1, 16'd0, '0, '0, 0, 0, '0));
        send_item(make_item(MODE_START, 16'hFFFF, 16'hFFFF, '1, '1, 1, 1, '1));
        wait_results_drained();
        write_register(ADDR_LEARNING_RATE, 32'hFFFF_FFFF);
        write_register(ADDR_STOP_THRESHOLD, 32'hFFFF_FFFF);
        send_item(make_item(MODE_START, 16'd0, 16'd0, '0, '0, 0, 0, '0));
        send_item(make_item(MODE_TERM, 16'd0, 16'd3, 40'd0, 40'd1, 1, 1, '0));
        send_item(make_item(MODE_START, 16'd0, 16'd0, '0, '0, 0, 0, '0));
        wait_results_drained();
        write_register(ADDR_LEARNING_RATE, 32'h0000_0000);
        write_register(ADDR_STOP_THRESHOLD, 32'h0000_0000);
        send_item(make_item(MODE_TERM, 16'd0, 16'd3, 40'd0, 40'd4, 1, 1, '0));
        send_item(make_item(MODE_START, 16'd0, 16'd0, '0, '0, 0, 0, '0));
    endtask

    // Random phases, each under a new register setting.
    task automatic test_random();
        logic [31:0] eta_pick;
        for (int phase = 0; phase < 6; phase++) begin
            wait_results_drained();
            case ($urandom_range(0, 3))
                0: eta_pick = 32'hFFFF_FFFF;
                1: eta_pick = 32'h0000_0000;
                default: eta_pick = 32'($urandom_range(1, 32'h0008_0000));
            endcase
            write_register(ADDR_LEARNING_RATE, eta_pick);
            write_register(ADDR_STOP_THRESHOLD,
                           ($urandom_range(0, 2) == 0) ? $urandom() : 32'($urandom_range(0, 65536)));
            for (int n = 0; n < 250; n++) send_item(random_item());
        end
    endtask

    // Closing stretch with no gaps or stalls.
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        for (int n = 0; n < 120; n++) send_item(random_item());
    endtask

    initial begin
        eta_reg = 32'h0001_0000;
        threshold_reg = '0;
        peak_step = '0;
        term_total = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_registers();
        test_directed();
        test_random();
        test_back_to_back();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
sv/sgdlpu_pkg.sv
sv/sgdlpu_ram.sv
sv/sgd_layout_position_update_top.sv
tb/sv/tb_top.sv
